// ----- sv/pic_pkg.sv -----
// Shared types and constants for the pair inversion counter.
package pic_pkg;

  localparam int PortPosW = 16;
  localparam int CountW = 15;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef struct packed {
    logic valid;
    logic last;
    logic placed;
  } tok_t;

endpackage

// ----- sv/pic_cell.sv -----
// One chain cell: holds one item and compares each unplaced passing transaction to it.
module pic_cell #(
  parameter int PW = 16,
  parameter int AW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  pic_pkg::tok_t     tok_i,
  input  logic [PW-1:0]     start_i,
  input  logic [PW-1:0]     end_i,
  input  logic [AW-1:0]     add_i,
  output pic_pkg::tok_t     tok_o,
  output logic [PW-1:0]     start_o,
  output logic [PW-1:0]     end_o,
  output logic [AW-1:0]     add_o
);
  import pic_pkg::*;

  logic          occ_q, occ_d;
  logic [PW-1:0] st_q, en_q;
  tok_t          tok_q, tok_d;
  logic [PW-1:0] start_q, end_q;
  logic [AW-1:0] add_q, add_d;
  logic          hit, place;

  always_comb begin
    hit = occ_q && tok_i.valid && !tok_i.placed &&
          (((st_q < start_i) && (en_q > end_i)) || ((start_i < st_q) && (end_i < en_q)));
    place = tok_i.valid && !tok_i.placed && !occ_q;
    add_d = add_i + AW'(hit);
    tok_d = tok_i;
    tok_d.placed = tok_i.placed || place;
    occ_d = occ_q;
    if (place) begin
      occ_d = 1'b1;
    end
    if (tok_i.valid && tok_i.last) begin
      occ_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      tok_q <= '0;
    end else if (adv_i) begin
      occ_q <= occ_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (place) begin
        st_q <= start_i;
        en_q <= end_i;
      end
      start_q <= start_i;
      end_q <= end_i;
      add_q <= add_d;
    end
  end

  assign tok_o = tok_q;
  assign start_o = start_q;
  assign end_o = end_q;
  assign add_o = add_q;

endmodule

// ----- sv/pic_tail.sv -----
// Chain tail: sums the per-transaction counts of a set and holds the result register.
module pic_tail #(
  parameter int AW = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pic_pkg::tok_t              tok_i,
  input  logic [AW-1:0]              add_i,
  input  logic                       out_stall_i,
  output logic                       adv_o,
  output logic                       out_valid_o,
  output logic [pic_pkg::CountW-1:0] pair_count_o,
  output logic                       overflow_o
);
  import pic_pkg::*;

  logic              run_ovf_q, run_ovf_d, ovf_new;
  logic [CountW-1:0] run_q, run_d, run_new;
  logic [CountW:0]   sum;
  logic              res_valid_q, res_valid_d;
  logic [CountW-1:0] res_count_q;
  logic              res_ovf_q;
  logic              take;

  always_comb begin
    adv_o = !(res_valid_q && out_stall_i && tok_i.valid && tok_i.last);
    take = adv_o && tok_i.valid;
    sum = {1'b0, run_q} + (CountW + 1)'(add_i);
    run_new = run_q;
    ovf_new = run_ovf_q;
    if (tok_i.placed) begin
      run_new = sum[CountW] ? CountMax : sum[CountW-1:0];
    end else begin
      ovf_new = 1'b1;
    end
    run_d = run_q;
    run_ovf_d = run_ovf_q;
    res_valid_d = res_valid_q && out_stall_i;
    if (take) begin
      run_d = run_new;
      run_ovf_d = ovf_new;
      if (tok_i.last) begin
        res_valid_d = 1'b1;
        run_d = '0;
        run_ovf_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
      run_ovf_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      run_q <= run_d;
      run_ovf_q <= run_ovf_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && tok_i.last) begin
      res_count_q <= run_new;
      res_ovf_q <= ovf_new;
    end
  end

  assign out_valid_o = res_valid_q;
  assign pair_count_o = res_count_q;
  assign overflow_o = res_ovf_q;

endmodule

// ----- sv/pair_inversion_counter_top.sv -----
// Pair inversion counter: a systolic row of item cells followed by a summing tail.
// Unless the chain is frozen, one transaction is taken and each walks one cell per
// cycle; a set's last item passes each cell register, then the result register.
// The chain freezes only while a held result is stalled and another set's last item
// reaches the tail. Reset empties every cell and clears the running count and flags.
module pair_inversion_counter_top #(
  parameter int MAX_ITEMS = 256,
  parameter int POS_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [pic_pkg::PortPosW-1:0] start_pos_i,
  input  logic [pic_pkg::PortPosW-1:0] end_pos_i,
  input  logic                       last_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [pic_pkg::CountW-1:0] pair_count_o,
  output logic                       overflow_o
);
  import pic_pkg::*;

  localparam int PW = (POS_BITS < PortPosW) ? POS_BITS : PortPosW;
  localparam int AW = $clog2(MAX_ITEMS);

  tok_t          tok_w   [MAX_ITEMS+1];
  logic [PW-1:0] start_w [MAX_ITEMS+1];
  logic [PW-1:0] end_w   [MAX_ITEMS+1];
  logic [AW-1:0] add_w   [MAX_ITEMS+1];
  logic          adv;

  assign in_stall_o = !adv;

  assign tok_w[0].valid = in_valid_i;
  assign tok_w[0].last = last_item_i;
  assign tok_w[0].placed = 1'b0;
  assign start_w[0] = start_pos_i[PW-1:0];
  assign end_w[0] = end_pos_i[PW-1:0];
  assign add_w[0] = '0;

  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    pic_cell #(
      .PW (PW),
      .AW (AW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .tok_i   (tok_w[k]),
      .start_i (start_w[k]),
      .end_i   (end_w[k]),
      .add_i   (add_w[k]),
      .tok_o   (tok_w[k+1]),
      .start_o (start_w[k+1]),
      .end_o   (end_w[k+1]),
      .add_o   (add_w[k+1])
    );
  end

  pic_tail #(
    .AW (AW)
  ) u_tail (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tok_i        (tok_w[MAX_ITEMS]),
    .add_i        (add_w[MAX_ITEMS]),
    .out_stall_i  (out_stall_i),
    .adv_o        (adv),
    .out_valid_o  (out_valid_o),
    .pair_count_o (pair_count_o),
    .overflow_o   (overflow_o)
  );

endmodule

// ----- sv/pic_checker.sv -----
// Port-level checker for the pair inversion counter, bound to the top level.
module pic_checker #(
  parameter int MaxItems = 256
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [pic_pkg::CountW-1:0]   pair_count_o,
  input logic                         overflow_o
);
  import pic_pkg::*;

  localparam longint PairsMax = longint'(MaxItems) * longint'(MaxItems - 1) / 2;
  localparam longint CountLimit = (PairsMax < 32767) ? PairsMax : 32767;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i)
    else $error("Input transaction withdrawn while stalled.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result transaction withdrawn while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pair_count_o) && $stable(overflow_o))
    else $error("Result payload changed while stalled.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled without a stalled result.");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> longint'(pair_count_o) <= CountLimit)
    else $error("Pair count exceeds the number of possible pairs.");

endmodule

bind pair_inversion_counter_top pic_checker #(
  .MaxItems (MAX_ITEMS)
) u_pic_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .pair_count_o (pair_count_o),
  .overflow_o   (overflow_o)
);

// ----- tb/pair_inversion_counter_checker.sv -----
// Checker for the pair inversion counter: predicts each set's pair count and compares results.
module pair_inversion_counter_checker #(
  parameter int MAX_ITEMS = 256,
  parameter int POS_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [pic_pkg::PortPosW-1:0] start_pos_i,
  input  logic [pic_pkg::PortPosW-1:0] end_pos_i,
  input  logic                         last_item_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [pic_pkg::CountW-1:0]   pair_count_i,
  input  logic                         overflow_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import pic_pkg::*;

  typedef struct packed {
    logic [CountW-1:0] pair_count;
    logic              overflow;
  } set_result_t;

  localparam int KeptBits = (POS_BITS < PortPosW) ? POS_BITS : PortPosW;
  localparam logic [PortPosW-1:0] PosMask = {PortPosW{1'b1}} >> (PortPosW - KeptBits);

  logic [PortPosW-1:0] held_start [MAX_ITEMS];
  logic [PortPosW-1:0] held_end [MAX_ITEMS];
  int                  held_total;
  int                  running_pairs;
  logic                dropped_any;
  set_result_t         awaited_results [$];

  function automatic int overtakes_of(input logic [PortPosW-1:0] s, input logic [PortPosW-1:0] e);
    int n;
    n = 0;
    for (int k = 0; k < held_total; k++) begin
      if ((held_start[k] < s && held_end[k] > e) || (s < held_start[k] && e < held_end[k])) begin
        n++;
      end
    end
    return n;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    set_result_t         want;
    logic [PortPosW-1:0] s;
    logic [PortPosW-1:0] e;
    if (!rst_ni) begin
      held_total = 0;
      running_pairs = 0;
      dropped_any = 1'b0;
      awaited_results.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        s = start_pos_i & PosMask;
        e = end_pos_i & PosMask;
        if (held_total < MAX_ITEMS) begin
          running_pairs = running_pairs + overtakes_of(s, e);
          if (running_pairs > CountMax) begin
            running_pairs = CountMax;
          end
          held_start[held_total] = s;
          held_end[held_total] = e;
          held_total++;
        end else begin
          dropped_any = 1'b1;
        end
        if (last_item_i) begin
          want.pair_count = running_pairs[CountW-1:0];
          want.overflow = dropped_any;
          awaited_results.insert(awaited_results.size(), want);
          held_total = 0;
          running_pairs = 0;
          dropped_any = 1'b0;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, pair_count %0d overflow %0b", $time,
                   pair_count_i, overflow_i);
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          if (pair_count_i !== want.pair_count) begin
            $display("%0t: pair_count expected %0d, actual %0d", $time, want.pair_count,
                     pair_count_i);
            fail_count_o++;
          end
          if (overflow_i !== want.overflow) begin
            $display("%0t: overflow expected %0b, actual %0b", $time, want.overflow,
                     overflow_i);
            fail_count_o++;
          end
        end
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

// ----- tb/pair_inversion_counter_top_test.sv -----
// Top of the pair inversion counter testbench: clock, reset, stimulus, watchdog and verdict.
module pair_inversion_counter_top_test;
  import pic_pkg::*;

  localparam int MaxItems = 256;
  localparam int PosBits = 16;
  localparam int ItemTarget = 1350;
  localparam int IdleLimit = 4000;
  localparam int HoldOffAfter = 8;
  localparam int HoldOffCycles = 800;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [PortPosW-1:0] start_pos_i;
  logic [PortPosW-1:0] end_pos_i;
  logic                last_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [CountW-1:0]   pair_count_o;
  logic                overflow_o;

  int fail_count;
  int pending;
  int items_sent;
  int idle_cycles;
  bit gaps_on;

  pair_inversion_counter_top #(
    .MAX_ITEMS(MaxItems),
    .POS_BITS (PosBits)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .start_pos_i (start_pos_i),
    .end_pos_i   (end_pos_i),
    .last_item_i (last_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pair_count_o(pair_count_o),
    .overflow_o  (overflow_o)
  );

  pair_inversion_counter_checker #(
    .MAX_ITEMS(MaxItems),
    .POS_BITS (PosBits)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .start_pos_i (start_pos_i),
    .end_pos_i   (end_pos_i),
    .last_item_i (last_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .pair_count_i(pair_count_o),
    .overflow_i  (overflow_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_item(input logic [PortPosW-1:0] s, input logic [PortPosW-1:0] e,
                           input logic l);
    int gap;
    gap = gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_pos_i <= s;
    end_pos_i <= e;
    last_item_i <= l;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  function automatic logic [PortPosW-1:0] pick_pos(input int style);
    case (style)
      0: return PortPosW'($urandom_range(0, 7));
      1: return ($urandom_range(0, 1) != 0) ? {PortPosW{1'b1}} : {PortPosW{1'b0}};
      default: return PortPosW'($urandom());
    endcase
  endfunction

  task automatic send_random_set(input int size);
    int style;
    style = $urandom_range(0, 3);
    for (int i = 0; i < size; i++) begin
      send_item(pick_pos(style), pick_pos(style), i == size - 1);
    end
  endtask

  initial begin
    int set_no;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    start_pos_i = '0;
    end_pos_i = '0;
    last_item_i = 1'b0;
    gaps_on = 1'b1;
    items_sent = 0;
    set_no = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Single-item sets at both ends of the position range.
    send_item(16'h0000, 16'h0000, 1'b1);
    send_item(16'hFFFF, 16'hFFFF, 1'b1);
    // Extreme positions, several pairs overtaking.
    send_item(16'h0000, 16'hFFFF, 1'b0);
    send_item(16'hFFFF, 16'h0000, 1'b0);
    send_item(16'h0001, 16'hFFFE, 1'b0);
    send_item(16'h8000, 16'h7FFF, 1'b1);
    // Equal starts, equal ends and identical items never count.
    send_item(16'd5, 16'd10, 1'b0);
    send_item(16'd5, 16'd20, 1'b1);
    send_item(16'd3, 16'd9, 1'b0);
    send_item(16'd4, 16'd9, 1'b1);
    send_item(16'd7, 16'd7, 1'b0);
    send_item(16'd7, 16'd7, 1'b1);
    // The inner item arrives before the one that encloses it.
    send_item(16'd10, 16'd10, 1'b0);
    send_item(16'd0, 16'd20, 1'b1);

    while (items_sent < ItemTarget) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      set_no++;
      case (set_no)
        5: begin
          // A full store of strictly nested items gives the largest count.
          for (int i = 0; i < MaxItems; i++) begin
            send_item(PortPosW'(100 + i), PortPosW'(1000 - i), i == MaxItems - 1);
          end
        end
        15: send_random_set(MaxItems + 1);
        30: send_random_set(MaxItems + 14);
        default: send_random_set($urandom_range(1, 16));
      endcase
    end
    in_valid_i <= 1'b0;

    wait (pending == 0);
    repeat (MaxItems + 16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    int wait_cycles;
    int taken;
    bit calm;
    out_stall_i = 1'b0;
    taken = 0;
    calm = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (taken % 16 == 0) begin
        calm = ($urandom_range(0, 2) == 0);
      end
      wait_cycles = calm ? 0 : $urandom_range(0, 11);
      // One long hold-off lets the chain fill up and push back on the sender.
      if (taken == HoldOffAfter) begin
        wait_cycles = HoldOffCycles;
      end
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

// ----- pair_inversion_counter_top.f -----
sv/pic_pkg.sv
sv/pic_cell.sv
sv/pic_tail.sv
sv/pair_inversion_counter_top.sv
sv/pic_checker.sv
tb/pair_inversion_counter_checker.sv
tb/pair_inversion_counter_top_test.sv
